// ===== rtl/assert_macros.svh =====
// Assertion helpers; every check is clocked on aclk and held off during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error("assertion failed");

// Trigger at one edge implies the consequent at the next edge.
`define ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/f9mac_pkg.sv =====
package f9mac_pkg;

    localparam int WORD_W     = 64;
    localparam int DIGIT_W    = 8;
    localparam int STEPS      = WORD_W / DIGIT_W;
    localparam int STEP_CNT_W = $clog2(STEPS);
    localparam int VB_W       = 7;
    localparam int LEN_W      = 32;
    localparam int MAC_W      = 32;
    localparam int IN_DATA_W  = 72;

    // x^64 = x^4 + x^3 + x + 1
    localparam logic [DIGIT_W-1:0] POLY_LOW = 8'h1b;
    localparam logic [VB_W-1:0]    FULL_VB  = 7'd64;

    // register indexes on the config port
    localparam logic [1:0] REG_EVAL_KEY_P  = 2'd0;
    localparam logic [1:0] REG_FINAL_KEY_Q = 2'd1;
    localparam logic [1:0] REG_OUTPUT_MASK = 2'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    // one digit step: r * x^8 + v * d, reduced
    function automatic logic [WORD_W-1:0] gf_step(
        input logic [WORD_W-1:0]  r,
        input logic [WORD_W-1:0]  v,
        input logic [DIGIT_W-1:0] d
    );
        logic [WORD_W+DIGIT_W-1:0] wide;
        logic [DIGIT_W-1:0]        hi;
        logic [DIGIT_W+3:0]        red;
        wide = {r, {DIGIT_W{1'b0}}};
        for (int i = 0; i < DIGIT_W; i++) begin
            if (d[i]) begin
                wide = wide ^ ({{DIGIT_W{1'b0}}, v} << i);
            end
        end
        hi  = wide[WORD_W+DIGIT_W-1:WORD_W];
        red = '0;
        for (int i = 0; i < DIGIT_W; i++) begin
            if (hi[i]) begin
                red = red ^ ({4'h0, POLY_LOW} << i);
            end
        end
        return wide[WORD_W-1:0] ^ {{(WORD_W-DIGIT_W-4){1'b0}}, red};
    endfunction

endpackage

// ===== rtl/f9mac_gfmul.sv =====
module f9mac_gfmul
    import f9mac_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [WORD_W-1:0] op_v,
    input  logic [WORD_W-1:0] op_k,
    output mul_stat_t         stat,
    output logic [WORD_W-1:0] result
);

    logic [WORD_W-1:0]     r_reg;
    logic [WORD_W-1:0]     v_reg;
    logic [WORD_W-1:0]     k_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    // key digits shift out MSB first, one per cycle while busy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + STEP_CNT_W'(1);
            if (cnt_reg == STEP_CNT_W'(STEPS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            r_reg <= '0;
            v_reg <= op_v;
            k_reg <= op_k;
        end else if (busy_reg) begin
            r_reg <= gf_step(r_reg, v_reg, k_reg[WORD_W-1 -: DIGIT_W]);
            k_reg <= {k_reg[WORD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = r_reg;

endmodule

// ===== rtl/gf64_poly_mac_f9.sv =====
// Channel   | Dir | Beat contents
// s_ (in)   | in  | tdata[63:0] block, tdata[70:64] valid_bits; tlast = last
// m_ (out)  | out | tdata[31:0] mac, one beat per message
// cfg_      | in  | write-only: 0 eval_key_p, 1 final_key_q, 2 output_mask
//
// Non-final beat: load + 8 digit steps + fold, using the 8-bit digit-serial
// GF(2^64) multiplier, which is shared by both products.
// Final beat: two multiplies back to back, then the output load of the tag.
// Reset (aresetn low, synchronous) clears the accumulator, bit count, keys.
// The tag sits in an output register; a new message is taken while it waits.
// A stalled tag only blocks the next final beat from finishing.
`include "assert_macros.svh"

module gf64_poly_mac_f9
    import f9mac_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // config write port
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_addr,
    input  logic [WORD_W-1:0]    cfg_wdata,
    // message blocks
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,   // [63:0] block, [70:64] valid_bits, [71] zero
    input  logic                 s_tlast,
    // tag
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [MAC_W-1:0]     m_tdata    // [31:0] mac
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL1 = 2'd1;  // (acc ^ block) * P
    localparam logic [1:0] ST_MUL2 = 2'd2;  // (acc ^ len) * Q
    localparam logic [1:0] ST_FIN  = 2'd3;  // tag waiting for the output register

    logic [1:0]        state_reg, state_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [LEN_W-1:0]  bitcnt_reg, bitcnt_next;
    logic              last_reg, last_next;
    logic [WORD_W-1:0] p_reg;
    logic [WORD_W-1:0] q_reg;
    logic [MAC_W-1:0]  mask_reg;
    logic              m_tvalid_reg, m_tvalid_next;
    logic [MAC_W-1:0]  m_tdata_reg, m_tdata_next;

    logic              mul_start;
    logic [WORD_W-1:0] mul_v;
    logic [WORD_W-1:0] mul_k;
    logic [WORD_W-1:0] mul_res;
    mul_stat_t         mul_stat;

    logic              in_accept;
    logic              out_load;
    logic              out_free;
    logic [VB_W-1:0]   vb_raw;
    logic [VB_W-1:0]   vb_eff;
    logic [VB_W-1:0]   add_bits;
    logic [WORD_W-1:0] keep;
    logic [LEN_W:0]    cnt_sum;

    f9mac_gfmul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_v    (mul_v),
        .op_k    (mul_k),
        .stat    (mul_stat),
        .result  (mul_res)
    );

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // zero or anything past 64 means a full block
    assign vb_raw   = s_tdata[WORD_W+VB_W-1:WORD_W];
    assign vb_eff   = (vb_raw == '0 || vb_raw > FULL_VB) ? FULL_VB : vb_raw;
    assign add_bits = s_tlast ? vb_eff : FULL_VB;
    assign keep     = s_tlast ? ~({WORD_W{1'b1}} >> vb_eff) : {WORD_W{1'b1}};
    assign cnt_sum  = {1'b0, bitcnt_reg} + {{(LEN_W+1-VB_W){1'b0}}, add_bits};

    always_comb begin
        state_next    = state_reg;
        acc_next      = acc_reg;
        bitcnt_next   = bitcnt_reg;
        last_next     = last_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        mul_start     = 1'b0;
        mul_v         = acc_reg ^ (s_tdata[WORD_W-1:0] & keep);
        mul_k         = p_reg;
        out_load      = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    mul_start   = 1'b1;
                    last_next   = s_tlast;
                    // saturating length count
                    bitcnt_next = cnt_sum[LEN_W] ? {LEN_W{1'b1}} : cnt_sum[LEN_W-1:0];
                    state_next  = ST_MUL1;
                end
            end
            ST_MUL1: begin
                if (mul_stat.done) begin
                    acc_next = mul_res;
                    if (last_reg) begin
                        mul_start  = 1'b1;
                        mul_v      = mul_res ^ {{(WORD_W-LEN_W){1'b0}}, bitcnt_reg};
                        mul_k      = q_reg;
                        state_next = ST_MUL2;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_MUL2: begin
                if (mul_stat.done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // product holds in the multiplier until the tag can leave
                if (out_free) begin
                    out_load = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = mul_res[WORD_W-1:WORD_W-MAC_W] ^ mask_reg;
            acc_next      = '0;
            bitcnt_next   = '0;
            state_next    = ST_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            acc_reg      <= '0;
            bitcnt_reg   <= '0;
            last_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            acc_reg      <= acc_next;
            bitcnt_reg   <= bitcnt_next;
            last_reg     <= last_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    // key registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_reg    <= '0;
            q_reg    <= '0;
            mask_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_EVAL_KEY_P:  p_reg    <= cfg_wdata;
                REG_FINAL_KEY_Q: q_reg    <= cfg_wdata;
                REG_OUTPUT_MASK: mask_reg <= cfg_wdata[MAC_W-1:0];
                default: ;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // input only taken with the multiplier free
    `ASSERT_ALWAYS(a_ready_mul_idle, !s_tready || !mul_stat.busy)
    // a product only completes inside a multiply state
    `ASSERT_ALWAYS(a_done_in_mul, !mul_stat.done || state_reg == ST_MUL1 || state_reg == ST_MUL2)
    // emitting a tag clears the message state
    `ASSERT_NEXT(a_tag_clears, out_load, acc_reg == '0 && bitcnt_reg == '0 && m_tvalid_reg)
    // a second multiply is only ever started for a final block
    `ASSERT_ALWAYS(a_mul2_last, state_reg != ST_MUL2 || last_reg)

endmodule

// ===== tb/tb_gf64_poly_mac_f9.sv =====
`timescale 1ns / 100ps

// Testbench for the f9 (UIA2) GF(2^64) polynomial MAC.
// Message blocks go in as stream beats. The tag for each message is predicted
// at the moment its final beat is accepted, and kept in a queue. Every tag beat
// coming out is compared with the oldest prediction. Keys change only between
// messages, and only once the block has gone idle.
module tb_gf64_poly_mac_f9;
    import f9mac_pkg::*;

    localparam logic [WORD_W-1:0] GF_POLY      = 64'h1b;    // x^4 + x^3 + x + 1
    localparam logic [WORD_W-1:0] ALL_ONES     = {WORD_W{1'b1}};
    localparam logic [LEN_W-1:0]  LEN_SAT      = {LEN_W{1'b1}};
    localparam logic [VB_W-1:0]   VB_FULL      = 7'd64;
    localparam int                DRAIN_CYCLES = 40;        // longer than an unstalled final beat
    localparam int                CYCLE_LIMIT  = 400000;
    localparam int                RANDOM_BEATS = 650;
    localparam int                RANDOM_PHASES = 5;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [1:0]           cfg_addr  = REG_EVAL_KEY_P;
    logic [WORD_W-1:0]    cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [IN_DATA_W-1:0] s_tdata   = '0;   // [63:0] block, [70:64] valid_bits, [71] zero
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [MAC_W-1:0]     m_tdata;          // [31:0] mac

    // Shadow copy of the keys and of the running message state.
    logic [WORD_W-1:0] key_p    = '0;
    logic [WORD_W-1:0] key_q    = '0;
    logic [MAC_W-1:0]  tag_mask = '0;
    logic [WORD_W-1:0] run_acc  = '0;
    logic [LEN_W-1:0]  run_bits = '0;

    logic [MAC_W-1:0]  pending_tags[$];
    logic [MAC_W-1:0]  want_tag;
    int                fail_cnt   = 0;
    int                beats_sent = 0;
    int                cycle_cnt  = 0;
    int                rx_stall   = 0;
    bit                steady     = 1'b0;   // no idling on either side when set

    gf64_poly_mac_f9 u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Bit-serial product in GF(2^64), MSB of the multiplier first.
    function automatic logic [WORD_W-1:0] gf64_mul(input logic [WORD_W-1:0] a,
                                                   input logic [WORD_W-1:0] b);
        logic [WORD_W-1:0] r;
        r = '0;
        for (int i = WORD_W - 1; i >= 0; i--) begin
            r = {r[WORD_W-2:0], 1'b0} ^ (r[WORD_W-1] ? GF_POLY : '0);
            if (b[i]) begin
                r = r ^ a;
            end
        end
        return r;
    endfunction

    // Fold one accepted beat into the running state. A final beat queues its tag.
    function automatic void absorb_beat(input logic [WORD_W-1:0] blk, input bit last,
                                        input logic [VB_W-1:0] vb);
        logic [VB_W-1:0]   used;
        logic [WORD_W-1:0] keep;
        logic [WORD_W-1:0] t;
        logic [LEN_W:0]    sum;
        // A zero or oversized valid_bits means a full block. valid_bits only
        // matters on the final beat.
        used = (!last || vb == 0 || vb > VB_FULL) ? VB_FULL : vb;
        keep = (used == VB_FULL) ? ALL_ONES : ~(ALL_ONES >> used);
        sum  = {1'b0, run_bits} + {{(LEN_W+1-VB_W){1'b0}}, used};
        run_bits = sum[LEN_W] ? LEN_SAT : sum[LEN_W-1:0];   // length saturates
        run_acc  = gf64_mul(run_acc ^ (blk & keep), key_p);
        if (last) begin
            t = gf64_mul(run_acc ^ {{(WORD_W-LEN_W){1'b0}}, run_bits}, key_q);
            pending_tags.push_back(t[WORD_W-1:WORD_W-MAC_W] ^ tag_mask);
            run_acc  = '0;
            run_bits = '0;
        end
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return ALL_ONES;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Send one beat. The task is entered at a falling edge and leaves at one. tvalid
    // stays high on return so back-to-back beats need no re-raise.
    task automatic send_beat(input logic [WORD_W-1:0] blk, input bit last,
                             input logic [VB_W-1:0] vb);
        int gap;
        if (!steady && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, vb, blk};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        absorb_beat(blk, last, vb);
        beats_sent++;
        @(negedge aclk);
    endtask

    // Wait for all tags to arrive, then wait out the drain period as well.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_tags.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Write all three registers. cfg_we stays high across the three writes.
    task automatic set_keys(input logic [WORD_W-1:0] p, input logic [WORD_W-1:0] q,
                            input logic [WORD_W-1:0] mask);
        drain();
        cfg_we    <= 1'b1;
        cfg_addr  <= REG_EVAL_KEY_P;
        cfg_wdata <= p;
        @(negedge aclk);
        cfg_addr  <= REG_FINAL_KEY_Q;
        cfg_wdata <= q;
        @(negedge aclk);
        cfg_addr  <= REG_OUTPUT_MASK;
        cfg_wdata <= mask;      // the upper half must be dropped
        @(negedge aclk);
        cfg_we    <= 1'b0;
        key_p    = p;
        key_q    = q;
        tag_mask = mask[MAC_W-1:0];
    endtask

    // One well-formed message with random content. Most messages are short and
    // a few are long. The final beat sometimes has a zero or oversized valid_bits.
    task automatic send_random_msg();
        int              len;
        logic [VB_W-1:0] vb;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 5);
        for (int i = 0; i < len - 1; i++) begin
            send_beat(rand_word(), 1'b0, VB_W'($urandom_range(0, 127)));
        end
        case ($urandom_range(0, 7))
            0: vb = '0;
            1: vb = VB_W'($urandom_range(65, 127));
            default: vb = VB_W'($urandom_range(1, 64));
        endcase
        send_beat(rand_word(), 1'b1, vb);
    endtask

    // Single-beat and short messages. Covers the edge cases of valid_bits
    // and of the data.
    task automatic test_short_messages();
        set_keys({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        send_beat('0, 1'b1, VB_FULL);
        send_beat(ALL_ONES, 1'b1, 7'd1);
        send_beat(ALL_ONES, 1'b1, 7'd0);          // zero: full block
        send_beat(rand_word(), 1'b1, 7'd65);      // oversized: saturates to 64
        send_beat(ALL_ONES, 1'b1, 7'd127);
        send_beat({$urandom, $urandom}, 1'b1, 7'd63);
        // valid_bits on a non-final beat is ignored
        send_beat({$urandom, $urandom}, 1'b0, 7'd127);
        send_beat({$urandom, $urandom}, 1'b1, 7'd32);
        send_beat('0, 1'b0, 7'd0);
        send_beat(ALL_ONES, 1'b0, 7'd1);
        send_beat({$urandom, $urandom}, 1'b1, VB_FULL);
    endtask

    // Degenerate and extreme keys: zero, all ones, and the identity.
    task automatic test_key_extremes();
        set_keys('0, ALL_ONES, ALL_ONES);
        send_beat({$urandom, $urandom}, 1'b1, VB_FULL);
        send_beat({$urandom, $urandom}, 1'b0, 7'd5);
        send_beat({$urandom, $urandom}, 1'b1, 7'd17);
        set_keys(64'h1, 64'h1, '0);
        send_beat(64'h8000_0000_0000_0000, 1'b0, 7'd0);
        send_beat({$urandom, $urandom}, 1'b0, 7'd0);
        send_beat({$urandom, $urandom}, 1'b1, 7'd40);
        set_keys(ALL_ONES, '0, 64'hffff_ffff_0000_0000);
        send_beat({$urandom, $urandom}, 1'b1, VB_FULL);
    endtask

    // Random traffic in phases, with fresh keys in each. The last phase runs
    // without idling on either side. A saturated length needs 2^26 beats, which
    // is far more than a simulation can run; the predictor still models it.
    task automatic test_random_traffic();
        int target;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            set_keys(rand_word(), rand_word(), rand_word());
            if (ph == RANDOM_PHASES - 1) begin
                steady = 1'b1;
            end
            target = beats_sent + RANDOM_BEATS / RANDOM_PHASES;
            while (beats_sent < target) send_random_msg();
        end
    endtask

    // Tag side: random stall bursts on m_tready.
    always @(negedge aclk) begin
        if (rx_stall > 0) begin
            rx_stall--;
            m_tready <= 1'b0;
        end else if (!steady && $urandom_range(0, 4) == 0) begin
            rx_stall = $urandom_range(0, 5);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each tag beat with the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_tags.size() == 0) begin
                $error("mac: no tag expected, got %h", m_tdata);
                fail_cnt++;
            end else begin
                want_tag = pending_tags.pop_front();
                if (m_tdata !== want_tag) begin
                    $error("mac: expected %h, got %h", want_tag, m_tdata);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("gf64_poly_mac_f9: mismatch");
            $finish;
        end
    end

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_short_messages();
        test_key_extremes();
        test_random_traffic();
        drain();
        if (fail_cnt == 0) begin
            $display("gf64_poly_mac_f9: match");
        end else begin
            $display("gf64_poly_mac_f9: mismatch");
        end
        $finish;
    end

endmodule
